// ----- src/rgb_led_chain_serializer_top_defines.svh -----
// assertion macros for the rgb led chain serializer checker
// no dependencies; expects clk_i and rst_ni in the scope of use
`ifndef RGB_LED_CHAIN_SERIALIZER_TOP_DEFINES_SVH
`define RGB_LED_CHAIN_SERIALIZER_TOP_DEFINES_SVH

// same-cycle implication
`define RGBLED_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgbled assertion failed");

// next-cycle implication
`define RGBLED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgbled assertion failed");

`endif

// ----- src/rgbled_pkg.sv -----
// shared types and constants of the rgb led chain serializer
// no dependencies
package rgbled_pkg;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SHOW  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_GAP  = 2'd3
  } phase_e;

  typedef enum logic {
    CS_ACCEPT = 1'b0,
    CS_EXEC   = 1'b1
  } ctl_state_e;

  typedef enum logic [1:0] {
    CFG_SHORT_TICKS = 2'd0,
    CFG_LONG_TICKS  = 2'd1,
    CFG_GAP_TICKS   = 2'd2
  } cfg_idx_e;

  localparam int unsigned PIXEL_W   = 24;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BIT_PTR_W = 5;
  localparam int unsigned TICK_W    = 16;

  localparam logic [7:0]         RESET_SHORT = 8'd4;
  localparam logic [7:0]         RESET_LONG  = 8'd12;
  localparam logic [TICK_W-1:0]  RESET_GAP   = 16'd30000;
  localparam logic [PIXEL_W-1:0] RESET_PIXEL = 24'h200000;
  localparam logic [BIT_PTR_W-1:0] LAST_BIT  = 5'd23;

  typedef struct packed {
    op_e        operation;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic sending;
    logic frame_done;
    logic accepted;
  } result_t;

endpackage

// ----- src/rgbled_if.sv -----
// valid/ready channels of the rgb led chain serializer
// no dependencies
interface rgbled_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, operation, pixel_index, red, green, blue, input ready);
  modport sink (input valid, operation, pixel_index, red, green, blue, output ready);
endinterface

interface rgbled_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic sending;
  logic frame_done;
  logic accepted;

  modport source (output valid, line_level, sending, frame_done, accepted, input ready);
  modport sink (input valid, line_level, sending, frame_done, accepted, output ready);
endinterface

// ----- src/rgb_led_chain_serializer_top.sv -----
// rgb led chain serializer: pixel ram, command sequencer and one-wire line timing
// depends on rgbled_pkg, rgbled_if and rgbled_ram
// an accepted item is registered, executed in the exec state, and its result registered for output
// the block takes no new item while it executes the last one
// the output register lets the next item in as soon as the result is taken
// reset: control registers and entry valid bits clear at once, timing registers take defaults;
// an entry never written reads as green 0x20, or zero after a clear; no clearing pass
module rgb_led_chain_serializer_top #(
  parameter int unsigned PIXELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rgbled_in_if.sink                     in_i,
  rgbled_out_if.source                  out_o,
  input  logic                          cfg_we_i,
  input  logic [rgbled_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rgbled_pkg::CFG_W-1:0]  cfg_data_i
);
  import rgbled_pkg::*;

  localparam int unsigned PW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [PW-1:0] LAST_PIX = PW'(PIXELS - 1);
  localparam logic [8:0]    PIX_LIM  = 9'(PIXELS);

  ctl_state_e           state_q, state_d;
  item_t                item_q, item_d;
  phase_e               phase_q, phase_d;
  logic [PW-1:0]        pix_ptr_q, pix_ptr_d;
  logic [BIT_PTR_W-1:0] bit_ptr_q, bit_ptr_d;
  logic [TICK_W-1:0]    tick_q, tick_d;
  logic                 line_q, line_d;
  logic                 cleared_q, cleared_d;
  logic [PIXELS-1:0]    written_q, written_d;
  logic [7:0]           short_q, long_q;
  logic [TICK_W-1:0]    gap_q;
  logic                 out_valid_q, out_valid_d;
  result_t              res_q, res_d;

  logic                 in_ready;
  logic                 ram_we;
  logic [PIXEL_W-1:0]   ram_rdata;
  logic [PIXEL_W-1:0]   entry;
  logic [BIT_PTR_W-1:0] bit_sel;
  logic                 cur_bit;
  logic [TICK_W-1:0]    tick_inc;
  logic                 acc;
  logic                 done;

  rgbled_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(PIXELS)
  ) u_pix_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(item_q.pixel_index[PW-1:0]),
    .wdata_i({item_q.green, item_q.red, item_q.blue}),
    .raddr_i(pix_ptr_q),
    .rdata_o(ram_rdata)
  );

  assign entry    = written_q[pix_ptr_q] ? ram_rdata : (cleared_q ? '0 : RESET_PIXEL);
  assign bit_sel  = LAST_BIT - bit_ptr_q;
  assign cur_bit  = entry[bit_sel];
  assign tick_inc = tick_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    phase_d     = phase_q;
    pix_ptr_d   = pix_ptr_q;
    bit_ptr_d   = bit_ptr_q;
    tick_d      = tick_q;
    line_d      = line_q;
    cleared_d   = cleared_q;
    written_d   = written_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    acc         = 1'b1;
    done        = 1'b0;

    case (state_q)
      CS_ACCEPT: begin
        in_ready = !out_valid_q || out_o.ready;
        if (in_ready && in_i.valid) begin
          item_d.operation   = op_e'(in_i.operation);
          item_d.pixel_index = in_i.pixel_index;
          item_d.red         = in_i.red;
          item_d.green       = in_i.green;
          item_d.blue        = in_i.blue;
          state_d            = CS_EXEC;
        end
      end
      CS_EXEC: begin
        if (item_q.operation != OP_TICK) begin
          if (phase_q != PH_IDLE) begin
            acc = 1'b0;
          end else begin
            case (item_q.operation)
              OP_SET: begin
                if ({1'b0, item_q.pixel_index} < PIX_LIM) begin
                  ram_we = 1'b1;
                  written_d[item_q.pixel_index[PW-1:0]] = 1'b1;
                end
              end
              OP_CLEAR: begin
                written_d = '0;
                cleared_d = 1'b1;
              end
              OP_SHOW: begin
                phase_d   = PH_HIGH;
                pix_ptr_d = '0;
                bit_ptr_d = '0;
                tick_d    = '0;
                line_d    = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end else begin
          case (phase_q)
            PH_HIGH: begin
              line_d = 1'b1;
              tick_d = tick_inc;
              if (tick_inc >= {8'd0, (cur_bit ? long_q : short_q)}) begin
                tick_d  = '0;
                phase_d = PH_LOW;
              end
            end
            PH_LOW: begin
              line_d = 1'b0;
              tick_d = tick_inc;
              if (tick_inc >= {8'd0, (cur_bit ? short_q : long_q)}) begin
                tick_d = '0;
                if (bit_ptr_q < LAST_BIT) begin
                  bit_ptr_d = bit_ptr_q + 1'b1;
                  phase_d   = PH_HIGH;
                end else if (pix_ptr_q != LAST_PIX) begin
                  bit_ptr_d = '0;
                  pix_ptr_d = pix_ptr_q + 1'b1;
                  phase_d   = PH_HIGH;
                end else begin
                  phase_d = PH_GAP;
                end
              end
            end
            PH_GAP: begin
              line_d = 1'b0;
              tick_d = tick_inc;
              if (tick_inc >= gap_q) begin
                tick_d    = '0;
                pix_ptr_d = '0;
                bit_ptr_d = '0;
                phase_d   = PH_IDLE;
                done      = 1'b1;
              end
            end
            default: begin
              line_d = 1'b0;
            end
          endcase
        end
        res_d.line_level = line_d;
        res_d.sending    = (phase_d != PH_IDLE);
        res_d.frame_done = done;
        res_d.accepted   = acc;
        out_valid_d      = 1'b1;
        state_d          = CS_ACCEPT;
      end
      default: begin
        state_d = CS_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_ACCEPT;
      phase_q     <= PH_IDLE;
      pix_ptr_q   <= '0;
      bit_ptr_q   <= '0;
      tick_q      <= '0;
      line_q      <= 1'b0;
      cleared_q   <= 1'b0;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pix_ptr_q   <= pix_ptr_d;
      bit_ptr_q   <= bit_ptr_d;
      tick_q      <= tick_d;
      line_q      <= line_d;
      cleared_q   <= cleared_d;
      written_q   <= written_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= RESET_SHORT;
      long_q  <= RESET_LONG;
      gap_q   <= RESET_GAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SHORT_TICKS: short_q <= cfg_data_i[7:0];
        CFG_LONG_TICKS:  long_q  <= cfg_data_i[7:0];
        CFG_GAP_TICKS:   gap_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.line_level = res_q.line_level;
  assign out_o.sending    = res_q.sending;
  assign out_o.frame_done = res_q.frame_done;
  assign out_o.accepted   = res_q.accepted;

endmodule

// ----- src/rgbled_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module rgbled_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rgbled_checker.sv -----
// port-level checks of the rgb led chain serializer, bound to the top level
// depends on rgb_led_chain_serializer_top_defines.svh
`include "rgb_led_chain_serializer_top_defines.svh"

module rgbled_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic line_level_i,
  input logic sending_i,
  input logic frame_done_i,
  input logic accepted_i
);

  logic [3:0] res;
  assign res = {line_level_i, sending_i, frame_done_i, accepted_i};

  // stalled result holds
  `RGBLED_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(res))
  // one item at a time
  `RGBLED_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i)
  // end of gap leaves the block idle with the line low
  `RGBLED_ASSERT(a_done_idle, out_valid_i && frame_done_i,
                 !sending_i && !line_level_i && accepted_i)
  // refusals only happen during a frame
  `RGBLED_ASSERT(a_refuse_busy, out_valid_i && !accepted_i, sending_i && !frame_done_i)

endmodule

bind rgb_led_chain_serializer_top rgbled_checker u_rgbled_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .line_level_i(out_o.line_level),
  .sending_i   (out_o.sending),
  .frame_done_i(out_o.frame_done),
  .accepted_i  (out_o.accepted)
);

// ----- test/tb_rgb_led_chain_serializer_top.sv -----
// testbench of rgb_led_chain_serializer_top: drives command and tick items and compares
// every result with a per-item predictor of the pixel store and line timing
// depends on rgbled_pkg, rgbled_if and rgb_led_chain_serializer_top
`timescale 1ns / 100ps

module tb_rgb_led_chain_serializer_top;
  import rgbled_pkg::*;

  localparam int unsigned PIX_N = 8;
  localparam int unsigned PIX_AW = $clog2(PIX_N);
  localparam int unsigned CYCLE_LIMIT = 200_000;

  class led_line_scoreboard;
    logic [PIXEL_W-1:0]   pix [PIX_N];
    logic [7:0]           ptr;
    logic [BIT_PTR_W-1:0] bitp;
    phase_e               ph;
    logic [TICK_W-1:0]    cnt;
    logic                 level;
    logic [7:0]           t_short;
    logic [7:0]           t_long;
    logic [TICK_W-1:0]    t_gap;
    result_t              expected_levels [$];
    int                   errors;

    function new();
      foreach (pix[i]) pix[i] = RESET_PIXEL;
      ptr = '0;
      bitp = '0;
      ph = PH_IDLE;
      cnt = '0;
      level = 1'b0;
      t_short = RESET_SHORT;
      t_long = RESET_LONG;
      t_gap = RESET_GAP;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_SHORT_TICKS: t_short = v[7:0];
        CFG_LONG_TICKS:  t_long = v[7:0];
        CFG_GAP_TICKS:   t_gap = v;
        default: ;
      endcase
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function logic data_bit();
      if (ptr >= PIX_N || bitp > LAST_BIT) return 1'b0;
      return pix[PIX_AW'(ptr)][LAST_BIT - bitp];
    endfunction

    function bit part_over(logic [TICK_W-1:0] len);
      cnt = cnt + 1'b1;
      return cnt >= len;
    endfunction

    function void take_command(item_t it);
      logic done;
      logic acc;
      done = 1'b0;
      acc = 1'b1;
      if (it.operation != OP_TICK) begin
        if (ph != PH_IDLE) begin
          acc = 1'b0;
        end else begin
          case (it.operation)
            OP_SET: if (it.pixel_index < PIX_N)
              pix[PIX_AW'(it.pixel_index)] = {it.green, it.red, it.blue};
            OP_CLEAR: foreach (pix[i]) pix[i] = '0;
            default: begin
              ph = PH_HIGH;
              ptr = '0;
              bitp = '0;
              cnt = '0;
              level = 1'b0;
            end
          endcase
        end
      end else begin
        case (ph)
          PH_HIGH: begin
            level = 1'b1;
            if (part_over({8'd0, data_bit() ? t_long : t_short})) begin
              cnt = '0;
              ph = PH_LOW;
            end
          end
          PH_LOW: begin
            level = 1'b0;
            if (part_over({8'd0, data_bit() ? t_short : t_long})) begin
              cnt = '0;
              if (bitp < LAST_BIT) begin
                bitp = bitp + 1'b1;
                ph = PH_HIGH;
              end else if (ptr + 1 < PIX_N) begin
                bitp = '0;
                ptr = ptr + 1'b1;
                ph = PH_HIGH;
              end else begin
                ph = PH_GAP;
              end
            end
          end
          PH_GAP: begin
            level = 1'b0;
            if (part_over(t_gap)) begin
              cnt = '0;
              ptr = '0;
              bitp = '0;
              ph = PH_IDLE;
              done = 1'b1;
            end
          end
          default: level = 1'b0;
        endcase
      end
      expected_levels.push_back(result_t'{level, ph != PH_IDLE, done, acc});
    endfunction

    function void check_result(result_t got);
      result_t want;
      string   names [4];
      names = '{"line_level", "sending", "frame_done", "accepted"};
      if (expected_levels.size() == 0) begin
        $error("result with nothing expected: %b", got);
        errors++;
        return;
      end
      want = expected_levels.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[3-i] !== want[3-i]) begin
          $error("%s expected %0b actual %0b", names[i], want[3-i], got[3-i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  rgbled_in_if  in_if ();
  rgbled_out_if out_if ();

  rgb_led_chain_serializer_top #(
    .PIXELS(PIX_N)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  led_line_scoreboard sb = new();

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned cycles = 0;
  bit          long_hold = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rgb_led_chain_serializer_top verification failed");
      $finish;
    end
  end

  // receiver with one long hold-off so the block backs up into its input
  initial begin
    int unsigned stall_cnt;
    bit          hold_used;
    stall_cnt = 0;
    hold_used = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold && !hold_used) begin
        hold_used = 1'b1;
        stall_cnt = 400;
      end
      if (stall_cnt != 0) begin
        stall_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(result_t'{out_if.line_level, out_if.sending, out_if.frame_done,
                                out_if.accepted});
  end

  function automatic item_t make_item(op_e op);
    item_t it;
    it.operation = op;
    it.pixel_index = ($urandom_range(99) < 85) ? 8'($urandom_range(PIX_N - 1)) : 8'($urandom);
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= it.operation;
    in_if.pixel_index <= it.pixel_index;
    in_if.red <= it.red;
    in_if.green <= it.green;
    in_if.blue <= it.blue;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.take_command(it);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected_levels.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [7:0] s, input logic [7:0] l, input logic [15:0] g);
    logic [CFG_W-1:0] vals [3];
    vals = '{{8'd0, s}, {8'd0, l}, g};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // ticks while the frame runs, with refused commands mixed in, up to max_items items
  task automatic finish_frame(input int unsigned noise_pct, input int unsigned max_items);
    int unsigned k;
    k = 0;
    while (sb.busy() && k < max_items) begin
      if ($urandom_range(99) < noise_pct)
        send_item(make_item(op_e'($urandom_range(2))));
      else
        send_item(make_item(OP_TICK));
      k++;
    end
  endtask

  task automatic run_round();
    int unsigned n;
    int unsigned r;
    op_e         op;
    n = $urandom_range(10, 2);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 75) op = OP_SET;
      else if (r < 82) op = OP_CLEAR;
      else op = OP_TICK;
      send_item(make_item(op));
    end
  endtask

  initial begin
    int unsigned src_pct [3];
    int unsigned sink_pct [3];
    src_pct = '{29, 69, 0};
    sink_pct = '{69, 29, 0};
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_SHORT_TICKS;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.operation <= OP_SET;
    in_if.pixel_index <= '0;
    in_if.red <= '0;
    in_if.green <= '0;
    in_if.blue <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero lengths: every part lasts one tick; unwritten entries keep their reset value
    src_idle_pct = src_pct[0];
    sink_idle_pct = sink_pct[0];
    set_timing(8'd0, 8'd0, 16'd0);
    send_item(item_t'{OP_TICK, 8'hff, 8'hff, 8'hff, 8'hff});
    send_item(item_t'{OP_SET, 8'h00, 8'hff, 8'hff, 8'hff});
    send_item(item_t'{OP_SET, 8'(PIX_N - 1), 8'ha5, 8'h5a, 8'h3c});
    send_item(item_t'{OP_SET, 8'(PIX_N), 8'hff, 8'hff, 8'hff});
    send_item(item_t'{OP_SET, 8'hff, 8'hff, 8'hff, 8'hff});
    send_item(item_t'{OP_SET, 8'h03, 8'h80, 8'h01, 8'hff});
    send_item(item_t'{OP_SHOW, 8'hff, 8'hff, 8'hff, 8'hff});
    send_item(item_t'{OP_SET, 8'h01, 8'hff, 8'hff, 8'hff});
    send_item(item_t'{OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00});

    // one frame spans the three segments, with new part lengths at each boundary
    for (int seg = 0; seg < 3; seg++) begin
      settle();
      src_idle_pct = src_pct[seg];
      sink_idle_pct = sink_pct[seg];
      case (seg)
        0: set_timing(8'd0, 8'd0, 16'd3);
        1: set_timing(8'd1, 8'd2, 16'd1);
        default: begin
          set_timing(8'd1, 8'd0, 16'd0);
          long_hold = 1'b1;
        end
      endcase
      finish_frame(3, (seg == 2) ? 2000 : 150);
    end

    // commands once the frame is over
    settle();
    send_item(item_t'{OP_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff});
    run_round();
    run_round();

    settle();
    if (sb.errors == 0) begin
      $display("rgb_led_chain_serializer_top verification clean");
    end else begin
      $display("rgb_led_chain_serializer_top verification failed");
    end
    $finish;
  end

endmodule
